// ----- src/assert_macros.svh -----
// Assertion macros shared by the decibel level converter RTL.
// Depends on nothing; the checks compile out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define DLC_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("same-cycle implication check failed");
`define DLC_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("next-cycle implication check failed");
`else
`define DLC_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define DLC_ASSERT_NXT(lbl, clk, rst_n, a, c)
`endif
`endif

// ----- src/dlc_pkg.sv -----
// Shared types and constants for the decibel level converter.
// Used by the log cell, the exp cell and the top level; depends on nothing.
package dlc_pkg;

  typedef enum logic [1:0] {
    CMD_POW_TO_DB = 2'd0,
    CMD_RMS_TO_DB = 2'd1,
    CMD_DB_TO_POW = 2'd2,
    CMD_DB_TO_RMS = 2'd3
  } cmd_t;

  localparam int LOG_STEPS = 24;
  localparam int EXP_TERMS = 14;
  localparam int DB_REF = 100;
  localparam int POW_DB_CAP = 870;
  localparam int RMS_DB_CAP = 485;

  // Scale factors in Q.28, ln 2 and one in Q.30.
  localparam logic [31:0] K_POW_Q28 = 32'd808071242;
  localparam logic [31:0] K_RMS_Q28 = 32'd1616142483;
  localparam logic [27:0] C_POW_Q28 = 28'd89172328;
  localparam logic [27:0] C_RMS_Q28 = 28'd44586164;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [30:0] ONE_Q30 = 31'd1073741824;

  typedef struct packed {
    logic [30:0] m;
    logic [23:0] frac;
  } log_st_t;

  typedef struct packed {
    cmd_t        cmd;
    logic        pos;
    logic [4:0]  e;
    logic [32:0] dq;
  } log_side_t;

  typedef struct packed {
    logic [30:0] term;
    logic [31:0] sum;
    logic [29:0] y;
  } exp_st_t;

  typedef struct packed {
    cmd_t        cmd;
    logic        pos;
    logic [11:0] n;
    logic [31:0] db;
  } exp_side_t;

endpackage

// ----- src/dlc_log_cell.sv -----
// One squaring step of the log2 fraction: squares the mantissa, emits one bit.
// Depends on dlc_pkg.
module dlc_log_cell
  import dlc_pkg::*;
(
  input  logic      clk,
  input  logic      en,
  input  log_st_t   st_i,
  input  log_side_t side_i,
  output log_st_t   st_o,
  output log_side_t side_o
);

  logic [61:0] sq;
  logic [31:0] m2;
  logic        sbit;
  log_st_t     st_nxt;
  log_st_t     st_r;
  log_side_t   side_r;

  always_comb begin
    sq = 62'(st_i.m) * 62'(st_i.m);
    m2 = sq[61:30];
    sbit = m2[31];
    // Once the square reaches two, halve it and record a one.
    st_nxt.m = sbit ? m2[31:1] : m2[30:0];
    st_nxt.frac = {st_i.frac[22:0], sbit};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
      side_r <= side_i;
    end
  end

  assign st_o = st_r;
  assign side_o = side_r;

endmodule

// ----- src/dlc_exp_cell.sv -----
// One series term of 2^frac: term = (term * y) / K, sum += term, over three stages.
// Depends on dlc_pkg.
module dlc_exp_cell
  import dlc_pkg::*;
#(
  parameter int K = 1
) (
  input  logic      clk,
  input  logic      en,
  input  exp_st_t   st_i,
  input  exp_side_t side_i,
  output exp_st_t   st_o,
  output exp_side_t side_o
);

  // floor(2^32 / K); the product estimate is low by at most one.
  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / K);

  logic [61:0] prod;
  logic [63:0] qprod;
  logic [30:0] rem;
  logic [30:0] q;

  logic [30:0] a_r, a2_r, q0_r;
  logic [31:0] sum1_r, sum2_r;
  logic [29:0] y1_r, y2_r;
  exp_side_t   side1_r, side2_r, side3_r;
  exp_st_t     st_r;
  exp_st_t     st_nxt;

  always_comb begin
    prod = 62'(st_i.term) * 62'(st_i.y);
    qprod = 64'(a_r) * 64'(RECIP);
    rem = a2_r - 31'(q0_r * 31'(K));
    q = (rem >= 31'(K)) ? q0_r + 31'd1 : q0_r;
    st_nxt.term = q;
    st_nxt.sum = sum2_r + 32'(q);
    st_nxt.y = y2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= prod[60:30];
      sum1_r <= st_i.sum;
      y1_r <= st_i.y;
      side1_r <= side_i;
      a2_r <= a_r;
      q0_r <= qprod[62:32];
      sum2_r <= sum1_r;
      y2_r <= y1_r;
      side2_r <= side1_r;
      st_r <= st_nxt;
      side3_r <= side2_r;
    end
  end

  assign st_o = st_r;
  assign side_o = side3_r;

endmodule

// ----- src/decibel_level_converter.sv -----
// Decibel level converter: power or RMS to dB and back on a 100 dB scale,
// signed Q.FRAC_BITS in, unsigned Q.FRAC_BITS out. One transfer is taken
// every cycle unless a stalled output holds the whole pipeline. Each result
// passes the input register, the 24 squaring cells of the log2 chain,
// three scaling stages, the 14 three-stage series cells of the exponent
// and the output register. No state is kept between transfers.
// Depends on dlc_pkg, dlc_log_cell, dlc_exp_cell and assert_macros.svh.
`include "assert_macros.svh"

module decibel_level_converter
  import dlc_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] result
  output logic [0:0]  out_tuser   // [0] saturated
);

  localparam int LAT = 1 + LOG_STEPS + 3 + 3 * EXP_TERMS + 1;
  localparam int SH = 52 - FRAC_BITS;
  localparam logic [39:0] POW_LIM = 40'(POW_DB_CAP) << FRAC_BITS;
  localparam logic [39:0] RMS_LIM = 40'(RMS_DB_CAP) << FRAC_BITS;
  localparam logic [39:0] REF_Q = 40'(DB_REF) << FRAC_BITS;
  localparam logic [63:0] DB_OFF = 64'(DB_REF) << 52;
  localparam logic [63:0] RND = 64'd1 << (SH - 1);

  logic           en;
  logic [LAT-1:0] vld_r;

  assign en = !vld_r[LAT-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // Input stage: normalize for log2 and clamp the dB operand.
  logic [30:0]        v;
  logic [4:0]         e;
  logic [39:0]        xw, lim, xc;
  log_st_t            log_st0_nxt;
  log_side_t          log_side0_nxt;

  always_comb begin
    v = in_tdata[30:0];
    e = '0;
    for (int i = 0; i < 31; i++) begin
      if (v[i]) begin
        e = 5'(i);
      end
    end
    log_st0_nxt.m = 31'(v << (5'd30 - e));
    log_st0_nxt.frac = '0;
    xw = {{8{in_tdata[31]}}, in_tdata};
    lim = (cmd_t'(in_tuser) == CMD_DB_TO_RMS) ? RMS_LIM : POW_LIM;
    xc = ($signed(xw) > $signed(lim)) ? lim : xw;
    log_side0_nxt.cmd = cmd_t'(in_tuser);
    log_side0_nxt.pos = !in_tdata[31] && (|in_tdata[30:0]);
    log_side0_nxt.e = e;
    log_side0_nxt.dq = 33'(xc - REF_Q);
  end

  log_st_t   log_st [LOG_STEPS+1];
  log_side_t log_side [LOG_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      log_st[0] <= log_st0_nxt;
      log_side[0] <= log_side0_nxt;
    end
  end

  for (genvar g = 0; g < LOG_STEPS; g++) begin : g_log
    dlc_log_cell u_cell (
      .clk    (clk),
      .en     (en),
      .st_i   (log_st[g]),
      .side_i (log_side[g]),
      .st_o   (log_st[g+1]),
      .side_o (log_side[g+1])
    );
  end

  // Scaling stage: log2 times the dB factor, and dB offset times log2(10)/10 or log2(10)/20.
  logic [7:0]         ediff;
  logic signed [31:0] lval;
  logic signed [63:0] lval64, kk64, dq64, cc64;
  logic signed [63:0] lprod_r, eprod_r;
  cmd_t               cmd1_r, cmd2_r;
  logic               pos1_r, pos2_r;

  always_comb begin
    ediff = 8'(log_side[LOG_STEPS].e) - 8'(FRAC_BITS);
    lval = $signed({ediff, log_st[LOG_STEPS].frac});
    lval64 = lval;
    kk64 = $signed({32'd0, (log_side[LOG_STEPS].cmd == CMD_RMS_TO_DB) ?
                           K_RMS_Q28 : K_POW_Q28});
    dq64 = $signed(log_side[LOG_STEPS].dq);
    cc64 = $signed({36'd0, (log_side[LOG_STEPS].cmd == CMD_DB_TO_RMS) ?
                           C_RMS_Q28 : C_POW_Q28});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lprod_r <= lval64 * kk64;
      eprod_r <= dq64 * cc64;
      cmd1_r <= log_side[LOG_STEPS].cmd;
      pos1_r <= log_side[LOG_STEPS].pos;
    end
  end

  // dB rounding, and the exponent split into integer and fraction.
  logic signed [63:0] p, t;
  logic [63:0]        rdb;
  logic [31:0]        db_nxt;
  logic [31:0]        db2_r;
  logic [11:0]        n2_r;
  logic [23:0]        fr2_r;

  always_comb begin
    p = lprod_r + $signed(DB_OFF);
    rdb = ($unsigned(p) + RND) >> SH;
    if (p <= 0) begin
      db_nxt = '0;
    end else if (rdb > 64'hFFFF_FFFF) begin
      db_nxt = '1;
    end else begin
      db_nxt = rdb[31:0];
    end
    t = eprod_r >>> (FRAC_BITS + 4);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      db2_r <= db_nxt;
      n2_r <= t[35:24];
      fr2_r <= t[23:0];
      cmd2_r <= cmd1_r;
      pos2_r <= pos1_r;
    end
  end

  // Fraction to natural-log units for the series.
  logic [53:0] yprod;
  exp_st_t     exp_st [EXP_TERMS+1];
  exp_side_t   exp_side [EXP_TERMS+1];

  assign yprod = 54'(fr2_r) * 54'(LN2_Q30);

  always_ff @(posedge clk) begin
    if (en) begin
      exp_st[0].term <= ONE_Q30;
      exp_st[0].sum <= 32'(ONE_Q30);
      exp_st[0].y <= yprod[53:24];
      exp_side[0].cmd <= cmd2_r;
      exp_side[0].pos <= pos2_r;
      exp_side[0].n <= n2_r;
      exp_side[0].db <= db2_r;
    end
  end

  for (genvar g = 0; g < EXP_TERMS; g++) begin : g_exp
    dlc_exp_cell #(.K(g + 1)) u_cell (
      .clk    (clk),
      .en     (en),
      .st_i   (exp_st[g]),
      .side_i (exp_side[g]),
      .st_o   (exp_st[g+1]),
      .side_o (exp_side[g+1])
    );
  end

  // Final scaling of 2^frac by 2^n and result selection.
  logic signed [11:0] s;
  logic [11:0]        ns;
  logic [32:0]        shl;
  logic [39:0]        wide;
  logic [31:0]        lin;
  logic               lin_sat;
  logic [31:0]        res_nxt;
  logic               sat_nxt;
  logic [31:0]        out_data_r;
  logic               out_sat_r;
  cmd_t               out_cmd_r;
  logic               out_pos_r;
  exp_st_t            es;
  exp_side_t          esd;

  always_comb begin
    es = exp_st[EXP_TERMS];
    esd = exp_side[EXP_TERMS];
    s = $signed(esd.n) + $signed(12'(FRAC_BITS)) - 12'sd30;
    ns = 12'(-s);
    shl = {1'b0, es.sum} << s[0];
    wide = ({8'd0, es.sum} + (40'd1 << (ns[5:0] - 6'd1))) >> ns[5:0];
    lin = '0;
    lin_sat = 1'b0;
    if (s >= 12'sd2) begin
      lin = '1;
      lin_sat = 1'b1;
    end else if (s >= 12'sd0) begin
      if (shl[32]) begin
        lin = '1;
        lin_sat = 1'b1;
      end else begin
        lin = shl[31:0];
      end
    end else if (ns < 12'd40) begin
      lin = wide[31:0];
    end
    if (!esd.pos) begin
      res_nxt = '0;
      sat_nxt = 1'b0;
    end else if (esd.cmd == CMD_POW_TO_DB || esd.cmd == CMD_RMS_TO_DB) begin
      res_nxt = esd.db;
      sat_nxt = 1'b0;
    end else begin
      res_nxt = lin;
      sat_nxt = lin_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= res_nxt;
      out_sat_r <= sat_nxt;
      out_cmd_r <= esd.cmd;
      out_pos_r <= esd.pos;
    end
  end

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata = out_data_r;
  assign out_tuser = out_sat_r;

  `DLC_ASSERT_IMP(a_sat_all_ones, clk, rst_n, out_tvalid && out_sat_r, out_data_r == '1)
  `DLC_ASSERT_IMP(a_db_no_sat, clk, rst_n,
    out_tvalid && (out_cmd_r == CMD_POW_TO_DB || out_cmd_r == CMD_RMS_TO_DB), !out_sat_r)
  `DLC_ASSERT_IMP(a_nonpos_zero, clk, rst_n, out_tvalid && !out_pos_r,
    out_data_r == '0 && !out_sat_r)
  `DLC_ASSERT_NXT(a_drain, clk, rst_n, out_tvalid && out_tready && !vld_r[LAT-2], !out_tvalid)

endmodule

// ----- dv/decibel_level_converter_test.sv -----
// Self-checking testbench for decibel_level_converter: a fixed-point predictor
// of the four level conversions checks every result transfer in order.
// Depends on dlc_pkg and the decibel_level_converter RTL.
`timescale 1ns / 1ps

module decibel_level_converter_test;
  import dlc_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = 71;

  typedef struct {
    logic [31:0] result;
    logic        saturated;
  } level_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [0:0]  out_tuser;

  level_t levels_due[$];
  int     mismatches;
  int     results_seen;

  decibel_level_converter #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("tb: failure");
    $finish;
  end

  // Arithmetic shift right that rounds toward minus infinity.
  function automatic longint floor_sh(longint v, int sh);
    return v >>> sh;
  endfunction

  // log2(v) - FRAC in signed Q.24, by repeated squaring of the mantissa.
  function automatic longint log2_q24(logic [31:0] v);
    int e;
    logic [63:0] m;
    longint frac;
    e = 30;
    frac = 0;
    while (e > 0 && !v[e]) e--;
    m = 64'(v) << (30 - e);
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      frac = frac <<< 1;
      if (m >= 64'd2147483648) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return longint'(e - FRAC) * 64'sd16777216 + frac;
  endfunction

  function automatic logic [31:0] level_to_db(longint x, longint k);
    longint p;
    logic [63:0] r;
    int sh;
    sh = 52 - FRAC;
    if (x <= 0) return '0;
    p = log2_q24(x[31:0]) * k + (longint'(DB_REF) <<< 52);
    if (p <= 0) return '0;
    r = (64'(p) + (64'd1 << (sh - 1))) >> sh;
    return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
  endfunction

  function automatic level_t db_to_level(longint x, longint cap, longint c);
    level_t o;
    longint d, t, n, s;
    logic [63:0] y, term, sum;
    o.result = '0;
    o.saturated = 1'b0;
    if (x <= 0) return o;
    if (x > (cap <<< FRAC)) x = cap <<< FRAC;
    d = (x - (longint'(DB_REF) <<< FRAC)) * (longint'(1) <<< (24 - FRAC));
    t = floor_sh(d * c, 28);
    n = floor_sh(t, 24);
    y = (64'(t - n * 64'sd16777216) * 64'(LN2_Q30)) >> 24;
    term = 64'(ONE_Q30);
    sum = 64'(ONE_Q30);
    for (int k = 1; k <= 14; k++) begin
      term = ((term * y) >> 30) / 64'(k);
      sum += term;
    end
    s = n + FRAC - 30;
    if (s >= 0) begin
      if (s >= 2 || (sum << s) > 64'hFFFF_FFFF) begin
        o.result = 32'hFFFF_FFFF;
        o.saturated = 1'b1;
      end else begin
        o.result = 32'(sum << s);
      end
    end else if (-s < 40) begin
      o.result = 32'((sum + (64'd1 << (-s - 1))) >> (-s));
    end
    return o;
  endfunction

  function automatic level_t convert_level(cmd_t cmd, logic [31:0] value);
    level_t o;
    longint x;
    x = longint'(signed'(value));
    o.saturated = 1'b0;
    case (cmd)
      CMD_POW_TO_DB: o.result = level_to_db(x, longint'(K_POW_Q28));
      CMD_RMS_TO_DB: o.result = level_to_db(x, longint'(K_RMS_Q28));
      CMD_DB_TO_POW: o = db_to_level(x, POW_DB_CAP, longint'(C_POW_Q28));
      default:       o = db_to_level(x, RMS_DB_CAP, longint'(C_RMS_Q28));
    endcase
    return o;
  endfunction

  // Sender burst bookkeeping: gaps are sometimes inserted between bursts.
  int burst_left;

  task automatic send_level(cmd_t cmd, logic [31:0] value);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 2) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= value;
    in_tuser <= cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    levels_due.push_back(convert_level(cmd, value));
  endtask

  task automatic idle_input();
    in_tvalid <= 1'b0;
  endtask

  task automatic drain_levels();
    idle_input();
    while (levels_due.size() != 0) @(posedge clk);
  endtask

  // Receiver stall pattern: phases of full throughput and phases of random stalls.
  initial begin
    int phase;
    out_tready = 1'b0;
    phase = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      phase = (phase + 1) % 300;
      if (phase < 100) out_tready <= 1'b1;
      else out_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (levels_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transfer: result=%h sat=%b", out_tdata, out_tuser);
      end else begin
        level_t want;
        want = levels_due.pop_front();
        if (want.result !== out_tdata || want.saturated !== out_tuser[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected result=%h sat=%b, got result=%h sat=%b",
                     want.result, want.saturated, out_tdata, out_tuser[0]);
        end
      end
    end
  end

  task automatic test_field_extremes();
    logic [31:0] edges[8];
    edges = '{32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000,
              32'hFFFF_FFFF, 32'h0001_0000, 32'h0064_0000, 32'hAAAA_5555};
    for (int c = 0; c < 4; c++)
      foreach (edges[i]) send_level(cmd_t'(c), edges[i]);
  endtask

  task automatic test_db_clamps();
    // Around the clamp points, saturating results, a tiny linear result and tiny levels.
    send_level(CMD_DB_TO_POW, 32'(870) << FRAC);
    send_level(CMD_DB_TO_POW, (32'(870) << FRAC) + 1);
    send_level(CMD_DB_TO_POW, 32'(190) << FRAC);
    send_level(CMD_DB_TO_RMS, 32'(485) << FRAC);
    send_level(CMD_DB_TO_RMS, (32'(485) << FRAC) + 1);
    send_level(CMD_DB_TO_RMS, 32'(200) << FRAC);
    send_level(CMD_DB_TO_RMS, 32'd1);
    send_level(CMD_POW_TO_DB, 32'd1);
    send_level(CMD_RMS_TO_DB, 32'd3);
  endtask

  task automatic test_random_levels(int count);
    logic [31:0] v;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0: v = $urandom;
        1: v = $urandom_range(1, 32'h00FF_FFFF);
        2: v = $urandom_range(0, 1000 << FRAC);
        default: v = 32'd1 << $urandom_range(0, 31);
      endcase
      send_level(cmd_t'($urandom_range(0, 3)), v);
      if (i == count / 2) drain_levels();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    mismatches = 0;
    results_seen = 0;
    burst_left = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_field_extremes();
    test_db_clamps();
    test_random_levels(600);
    drain_levels();
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatches == 0 && levels_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
